[hw/rtl/tps_pkg.sv]
// Shared types, codes and helpers for the trigger pulse scheduler.
`timescale 1ns / 1ps
`default_nettype none

package tps_pkg;

  localparam int CountWidth = 16;
  localparam int ValWidth   = 16;
  localparam int AddrWidth  = 5;
  localparam int DataWidth  = 32;

  // input word kinds
  localparam logic [1:0] KindTick   = 2'd0;
  localparam logic [1:0] KindUpdate = 2'd1;
  localparam logic [1:0] KindInit   = 2'd2;

  // output kinds
  localparam logic [1:0] OutNone    = 2'd0;
  localparam logic [1:0] OutServo   = 2'd1;
  localparam logic [1:0] OutDigital = 2'd2;

  // register indexes
  localparam logic [2:0] RegTriggerMode  = 3'd0;
  localparam logic [2:0] RegOutputKind   = 3'd1;
  localparam logic [2:0] RegDigitalFree  = 3'd2;
  localparam logic [2:0] RegPulseTicks   = 3'd3;
  localparam logic [2:0] RegRepeatTicks  = 3'd4;
  localparam logic [2:0] RegServoHigh    = 3'd5;
  localparam logic [2:0] RegServoLow     = 3'd6;

  typedef enum logic [1:0] {
    ModePulseHigh = 2'd0,
    ModePulseLow  = 2'd1,
    ModeToggle    = 2'd2,
    ModeRepeat    = 2'd3
  } trig_mode_e;

  typedef struct packed {
    trig_mode_e          trigger_mode;
    logic [1:0]          output_kind;
    logic                digital_line_free;
    logic [ValWidth-1:0] pulse_ticks;
    logic [ValWidth-1:0] repeat_ticks;
    logic [ValWidth-1:0] servo_high;
    logic [ValWidth-1:0] servo_low;
  } cfg_t;

  typedef struct packed {
    logic [CountWidth-1:0] start_cnt;
    logic [CountWidth-1:0] stop_cnt;
    logic                  level;
    logic                  req_held;
  } state_t;

  typedef struct packed {
    logic                trigger_level;
    logic [ValWidth-1:0] servo_value;
    logic                servo_write;
    logic                digital_write;
  } result_t;

  // zero-extend or truncate a 16-bit load to the counter width
  function automatic logic [CountWidth-1:0] to_count(input logic [ValWidth-1:0] v);
    logic [CountWidth+ValWidth-1:0] tmp;
    tmp = {{CountWidth{1'b0}}, v};
    return tmp[CountWidth-1:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/trigger_pulse_scheduler_top.sv]
// Top level of the trigger pulse scheduler: handshake, state and result registers.
//
// Input channel (in_valid_i / in_ready_o) carries one word per control event:
// kind_i selects tick, behaviour update or init; trigger_requested_i is the
// request bit of an update. Every accepted word gives exactly one result word
// on the output channel (out_valid_o / out_ready_i): the trigger level after
// the word, the servo width written and the servo / digital write flags.
// A word is captured in the input register; the step logic then updates the
// countdowns and level and loads the result register when the output is empty or
// read. One word per cycle is sustained while out_ready_i is high, as set by the
// single register-to-register step. While the receiver stalls the result register
// holds; the input register still takes one more word, after which in_ready_o
// drops until out_ready_i. Reset clears both countdowns, the level and the held
// request, empties both registers and loads the configuration defaults.
// Configuration is written over the APB port (register i at byte address 4*i);
// the user must write only while no word is in flight; the block does not check.
`timescale 1ns / 1ps
`default_nettype none

module trigger_pulse_scheduler_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tps_pkg::AddrWidth-1:0] paddr,
  input  wire logic [tps_pkg::DataWidth-1:0] pwdata,
  output logic      [tps_pkg::DataWidth-1:0] prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    kind_i,
  input  wire logic                          trigger_requested_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               trigger_level_o,
  output logic      [tps_pkg::ValWidth-1:0]  servo_value_o,
  output logic                               servo_write_o,
  output logic                               digital_write_o
);
  import tps_pkg::*;

  cfg_t    cfg;
  state_t  state_q, state_d;
  result_t res_q, res_d;
  logic    in_valid_q, out_valid_q;
  logic [1:0] kind_q;
  logic    req_q;
  logic    advance;

  tps_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tps_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .kind_i  (kind_q),
    .req_i   (req_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      kind_q <= kind_i;
      req_q  <= trigger_requested_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign trigger_level_o = res_q.trigger_level;
  assign servo_value_o   = res_q.servo_value;
  assign servo_write_o   = res_q.servo_write;
  assign digital_write_o = res_q.digital_write;

  // the input is always ready while the output stage is empty
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output stage");

  a_one_write_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(servo_write_o && digital_write_o))
    else $error("servo and digital writes in one word");

  a_servo_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !servo_write_o) |-> (servo_value_o == '0))
    else $error("servo value without servo write");

  a_level_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(advance) |-> (trigger_level_o == state_q.level))
    else $error("result level differs from held level");

endmodule

`default_nettype wire

[hw/rtl/tps_cfg_regs.sv]
// APB configuration registers of the trigger pulse scheduler.
`timescale 1ns / 1ps
`default_nettype none

module tps_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tps_pkg::AddrWidth-1:0] paddr,
  input  wire logic [tps_pkg::DataWidth-1:0] pwdata,
  output logic      [tps_pkg::DataWidth-1:0] prdata,
  output logic                               pready,
  output tps_pkg::cfg_t                      cfg_o
);
  import tps_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[AddrWidth-1:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_mode      <= ModePulseHigh;
      cfg_q.output_kind       <= OutNone;
      cfg_q.digital_line_free <= 1'b1;
      cfg_q.pulse_ticks       <= 16'd10;
      cfg_q.repeat_ticks      <= 16'd40;
      cfg_q.servo_high        <= 16'd4000;
      cfg_q.servo_low         <= 16'd2000;
    end else if (wr_en) begin
      case (idx)
        RegTriggerMode: cfg_q.trigger_mode      <= trig_mode_e'(pwdata[1:0]);
        RegOutputKind:  cfg_q.output_kind       <= pwdata[1:0];
        RegDigitalFree: cfg_q.digital_line_free <= pwdata[0];
        RegPulseTicks:  cfg_q.pulse_ticks       <= pwdata[ValWidth-1:0];
        RegRepeatTicks: cfg_q.repeat_ticks      <= pwdata[ValWidth-1:0];
        RegServoHigh:   cfg_q.servo_high        <= pwdata[ValWidth-1:0];
        RegServoLow:    cfg_q.servo_low         <= pwdata[ValWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      RegTriggerMode: prdata[1:0]          = cfg_q.trigger_mode;
      RegOutputKind:  prdata[1:0]          = cfg_q.output_kind;
      RegDigitalFree: prdata[0]            = cfg_q.digital_line_free;
      RegPulseTicks:  prdata[ValWidth-1:0] = cfg_q.pulse_ticks;
      RegRepeatTicks: prdata[ValWidth-1:0] = cfg_q.repeat_ticks;
      RegServoHigh:   prdata[ValWidth-1:0] = cfg_q.servo_high;
      RegServoLow:    prdata[ValWidth-1:0] = cfg_q.servo_low;
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/tps_step.sv]
// Next-state and result logic for one input word of the trigger scheduler.
`timescale 1ns / 1ps
`default_nettype none

module tps_step (
  input  wire tps_pkg::cfg_t   cfg_i,
  input  wire tps_pkg::state_t state_i,
  input  wire logic [1:0] kind_i,
  input  wire logic       req_i,
  output tps_pkg::state_t state_o,
  output tps_pkg::result_t res_o
);
  import tps_pkg::*;

  function automatic result_t drive(input cfg_t c, input logic lvl, input result_t r_in);
    result_t r;
    r = r_in;
    if (c.output_kind == OutServo) begin
      r.servo_value = lvl ? c.servo_high : c.servo_low;
      r.servo_write = 1'b1;
    end else if (c.output_kind == OutDigital && c.digital_line_free) begin
      r.digital_write = 1'b1;
    end
    r.trigger_level = lvl;
    return r;
  endfunction

  logic idle_lvl;
  assign idle_lvl = (cfg_i.trigger_mode != ModePulseHigh);

  always_comb begin
    state_t  s;
    result_t r;
    s = state_i;
    r = '0;
    r.trigger_level = state_i.level;
    case (kind_i)
      KindTick: begin
        // stop countdown first
        if (s.stop_cnt == CountWidth'(1)) begin
          r = drive(cfg_i, idle_lvl, r);
          s.stop_cnt = '0;
        end else if (s.stop_cnt != '0) begin
          s.stop_cnt = s.stop_cnt - CountWidth'(1);
        end
        if (s.start_cnt == CountWidth'(1) && s.req_held) begin
          case (cfg_i.trigger_mode)
            ModePulseHigh, ModePulseLow: begin
              r = drive(cfg_i, cfg_i.trigger_mode == ModePulseHigh, r);
              s.stop_cnt  = to_count(cfg_i.pulse_ticks);
              s.start_cnt = '0;
            end
            ModeToggle: begin
              r = drive(cfg_i, !r.trigger_level, r);
              s.stop_cnt  = '0;
              s.start_cnt = '0;
            end
            default: begin
              r = drive(cfg_i, 1'b0, r);
              s.stop_cnt  = to_count(cfg_i.pulse_ticks);
              s.start_cnt = to_count(cfg_i.repeat_ticks);
            end
          endcase
        end else if (s.start_cnt != '0) begin
          s.start_cnt = s.start_cnt - CountWidth'(1);
        end
      end
      KindUpdate: begin
        s.req_held = req_i;
        if (!req_i) begin
          s.start_cnt = '0;
        end else if (s.start_cnt == '0) begin
          s.start_cnt = CountWidth'(1);
        end
      end
      KindInit: begin
        s.req_held  = 1'b0;
        s.start_cnt = '0;
        if (cfg_i.output_kind == OutServo || cfg_i.output_kind == OutDigital) begin
          r = drive(cfg_i, idle_lvl, r);
        end
      end
      default: ;
    endcase
    s.level = r.trigger_level;
    state_o = s;
    res_o   = r;
  end

endmodule

`default_nettype wire

[dv/trigger_pulse_scheduler_top_tb.sv]
// Self-checking testbench for the trigger pulse scheduler top level.
`timescale 1ns / 1ps

module trigger_pulse_scheduler_top_tb;
  import tps_pkg::*;

  localparam logic [1:0] KindUnused = 2'd3;
  localparam logic [1:0] OutUnused  = 2'd3;
  localparam int         GapMax     = 19;
  localparam int         HoldCycles = 250;
  localparam int         WordsPerSetting = 165;
  localparam longint     CycleLimit = 400000;

  typedef struct {
    logic [1:0] kind;
    logic       req;
  } trig_word_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [DataWidth-1:0] pwdata = '0;
  logic [DataWidth-1:0] prdata;
  logic                 pready;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           kind_i = KindTick;
  logic                 trigger_requested_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 trigger_level_o;
  logic [ValWidth-1:0]  servo_value_o;
  logic                 servo_write_o;
  logic                 digital_write_o;

  trigger_pulse_scheduler_top dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .kind_i              (kind_i),
    .trigger_requested_i (trigger_requested_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .trigger_level_o     (trigger_level_o),
    .servo_value_o       (servo_value_o),
    .servo_write_o       (servo_write_o),
    .digital_write_o     (digital_write_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  cfg_t       sched_cfg;
  state_t     sched_st;
  trig_word_t word_queue[$];
  result_t    level_expect[$];

  int     tx_gap_max = GapMax;
  int     rx_gap_max = GapMax;
  int     tx_wait = 0;
  int     rx_wait = 0;
  int     hold_asked = 0;
  int     hold_served = 0;
  int     hold_left = 0;
  int     mismatch_cnt = 0;
  int     words_sent = 0;
  int     words_checked = 0;
  int     servo_seen = 0;
  int     digital_seen = 0;
  int     setting_cnt = 0;
  longint cycle_cnt = 0;

  // scheduler prediction
  function automatic void put_level(input logic lvl, inout result_t r);
    if (sched_cfg.output_kind == OutServo) begin
      r.servo_value = lvl ? sched_cfg.servo_high : sched_cfg.servo_low;
      r.servo_write = 1'b1;
    end else if (sched_cfg.output_kind == OutDigital && sched_cfg.digital_line_free) begin
      r.digital_write = 1'b1;
    end
    sched_st.level = lvl;
  endfunction

  function automatic result_t predict_trigger(input logic [1:0] kind, input logic req);
    result_t r;
    logic    idle_lvl;
    r = '0;
    idle_lvl = (sched_cfg.trigger_mode != ModePulseHigh);
    case (kind)
      KindTick: begin
        if (sched_st.stop_cnt == 1) begin
          put_level(idle_lvl, r);
          sched_st.stop_cnt = '0;
        end else if (sched_st.stop_cnt != 0) begin
          sched_st.stop_cnt = sched_st.stop_cnt - 1'b1;
        end
        if (sched_st.start_cnt == 1 && sched_st.req_held) begin
          case (sched_cfg.trigger_mode)
            ModePulseHigh, ModePulseLow: begin
              put_level(sched_cfg.trigger_mode == ModePulseHigh, r);
              sched_st.stop_cnt  = sched_cfg.pulse_ticks;
              sched_st.start_cnt = '0;
            end
            ModeToggle: begin
              put_level(~sched_st.level, r);
              sched_st.stop_cnt  = '0;
              sched_st.start_cnt = '0;
            end
            default: begin
              put_level(1'b0, r);
              sched_st.stop_cnt  = sched_cfg.pulse_ticks;
              sched_st.start_cnt = sched_cfg.repeat_ticks;
            end
          endcase
        end else if (sched_st.start_cnt != 0) begin
          sched_st.start_cnt = sched_st.start_cnt - 1'b1;
        end
      end
      KindUpdate: begin
        sched_st.req_held = req;
        if (!req) sched_st.start_cnt = '0;
        else if (sched_st.start_cnt == 0) sched_st.start_cnt = CountWidth'(1);
      end
      KindInit: begin
        sched_st.req_held  = 1'b0;
        sched_st.start_cnt = '0;
        if (sched_cfg.output_kind == OutServo || sched_cfg.output_kind == OutDigital) begin
          put_level(idle_lvl, r);
        end
      end
      default: ;
    endcase
    r.trigger_level = sched_st.level;
    return r;
  endfunction

  function automatic void queue_word(input logic [1:0] kind, input logic req);
    trig_word_t w;
    w.kind = kind;
    w.req  = req;
    word_queue.push_back(w);
  endfunction

  // mostly arm-then-tick bursts, the rest loose noise
  function automatic void queue_random_words(input int n);
    int made;
    int burst;
    int k;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 3) != 0) begin
        queue_word(KindUpdate, 1'b1);
        made++;
        burst = $urandom_range(1, 24);
        for (k = 0; k < burst; k++) begin
          case ($urandom_range(0, 19))
            0: queue_word(KindUpdate, 1'b0);
            1: queue_word(KindInit, 1'($urandom_range(0, 1)));
            2: queue_word(KindUpdate, 1'b1);
            default: queue_word(KindTick, 1'($urandom_range(0, 1)));
          endcase
          made++;
        end
      end else begin
        burst = $urandom_range(1, 6);
        for (k = 0; k < burst; k++) begin
          queue_word(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
          made++;
        end
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  task automatic apb_write(input logic [2:0] idx, input logic [DataWidth-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegTriggerMode: sched_cfg.trigger_mode      = trig_mode_e'(val[1:0]);
      RegOutputKind:  sched_cfg.output_kind       = val[1:0];
      RegDigitalFree: sched_cfg.digital_line_free = val[0];
      RegPulseTicks:  sched_cfg.pulse_ticks       = val[15:0];
      RegRepeatTicks: sched_cfg.repeat_ticks      = val[15:0];
      RegServoHigh:   sched_cfg.servo_high        = val[15:0];
      RegServoLow:    sched_cfg.servo_low         = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_registers(input trig_mode_e mode, input logic [1:0] okind,
                               input logic free, input logic [15:0] pulse,
                               input logic [15:0] rep, input logic [15:0] hi,
                               input logic [15:0] lo);
    apb_write(RegTriggerMode, 32'(mode));
    apb_write(RegOutputKind, 32'(okind));
    apb_write(RegDigitalFree, 32'(free));
    apb_write(RegPulseTicks, 32'(pulse));
    apb_write(RegRepeatTicks, 32'(rep));
    apb_write(RegServoHigh, 32'(hi));
    apb_write(RegServoLow, 32'(lo));
    setting_cnt++;
    @(negedge clk_i);
  endtask

  task automatic drain;
    while (word_queue.size() != 0 || in_valid_i || level_expect.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // sender
  always @(posedge clk_i) begin : word_driver
    logic nxt_valid;
    trig_word_t w;
    if (rst_ni) begin
      nxt_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        level_expect.push_back(predict_trigger(kind_i, trigger_requested_i));
        words_sent++;
        nxt_valid = 1'b0;
        tx_wait = $urandom_range(0, tx_gap_max);
      end
      if (!nxt_valid) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (word_queue.size() != 0) begin
          w = word_queue.pop_front();
          kind_i              <= w.kind;
          trigger_requested_i <= w.req;
          nxt_valid = 1'b1;
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left   <= HoldCycles;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin : result_checker
    result_t want;
    logic    nxt_ready;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (level_expect.size() == 0) begin
          $error("result word with no expectation pending: level %0d servo %0d",
                 trigger_level_o, servo_value_o);
          mismatch_cnt++;
        end else begin
          want = level_expect.pop_front();
          check_field("trigger_level", 16'(want.trigger_level), 16'(trigger_level_o));
          check_field("servo_value", want.servo_value, servo_value_o);
          check_field("servo_write", 16'(want.servo_write), 16'(servo_write_o));
          check_field("digital_write", 16'(want.digital_write), 16'(digital_write_o));
          words_checked++;
          if (want.servo_write) servo_seen++;
          if (want.digital_write) digital_seen++;
        end
        rx_wait = $urandom_range(0, rx_gap_max);
      end
      nxt_ready = 1'b0;
      if (rx_wait > 0) rx_wait--;
      else nxt_ready = (hold_left == 0);
      out_ready_i <= nxt_ready;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, level_expect.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int          ph;
    logic [15:0] pulse;
    logic [15:0] rep;
    logic [15:0] hi;
    logic [15:0] lo;
    logic [1:0]  okind;
    sched_cfg.trigger_mode      = ModePulseHigh;
    sched_cfg.output_kind       = OutNone;
    sched_cfg.digital_line_free = 1'b1;
    sched_cfg.pulse_ticks       = 16'd10;
    sched_cfg.repeat_ticks      = 16'd40;
    sched_cfg.servo_high        = 16'd4000;
    sched_cfg.servo_low         = 16'd2000;
    sched_st = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings, no output: unused kind, fire, init keeps level
    queue_word(KindUnused, 1'b1);
    queue_word(KindUpdate, 1'b1);
    queue_word(KindTick, 1'b0);
    queue_word(KindInit, 1'b0);
    queue_word(KindTick, 1'b1);
    queue_word(KindUpdate, 1'b0);
    drain();

    // repeating at period one: stop and start land on the same tick
    set_registers(ModeRepeat, OutServo, 1'b1, 16'd1, 16'd1, 16'hFFFF, 16'h0000);
    queue_word(KindUpdate, 1'b1);
    queue_word(KindTick, 1'b0);
    queue_word(KindTick, 1'b0);
    queue_word(KindTick, 1'b1);
    queue_word(KindInit, 1'b1);
    queue_word(KindUpdate, 1'b0);
    drain();

    // toggle on a busy digital line
    set_registers(ModeToggle, OutDigital, 1'b0, 16'd0, 16'd0, 16'h0000, 16'hFFFF);
    queue_word(KindUpdate, 1'b1);
    queue_word(KindTick, 1'b0);
    queue_word(KindUpdate, 1'b1);
    queue_word(KindTick, 1'b0);
    queue_word(KindInit, 1'b0);
    drain();

    // zero pulse and zero period: fires once, level held
    set_registers(ModeRepeat, OutDigital, 1'b1, 16'd0, 16'd0, 16'd1234, 16'd4321);
    queue_word(KindUpdate, 1'b1);
    queue_word(KindTick, 1'b0);
    queue_word(KindTick, 1'b0);
    queue_word(KindTick, 1'b0);
    queue_word(KindInit, 1'b0);
    drain();

    for (ph = 0; ph < 10; ph++) begin
      case (ph % 5)
        0: begin pulse = 16'd1; rep = 16'd1; end
        1: begin pulse = 16'hFFFF; rep = 16'd0; end
        2: begin pulse = 16'd0; rep = 16'hFFFF; end
        default: begin
          pulse = 16'($urandom_range(1, 8));
          rep   = 16'($urandom_range(1, 12));
        end
      endcase
      if (ph == 8) okind = OutNone;
      else if (ph == 9) okind = OutUnused;
      else okind = (ph % 2 != 0) ? OutServo : OutDigital;
      hi = (ph == 4) ? 16'h0000 : 16'($urandom_range(0, 65535));
      lo = (ph == 4) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      set_registers(trig_mode_e'(ph % 4), okind, ph % 3 != 1, pulse, rep, hi, lo);
      tx_gap_max = (ph == 5 || ph == 6) ? 0 : GapMax;
      rx_gap_max = (ph == 5) ? 0 : GapMax;
      queue_random_words(WordsPerSetting);
      if (ph == 3) hold_asked++;
      drain();
    end

    repeat (8) @(posedge clk_i);
    $display("%0d words sent and %0d results checked over %0d register settings",
             words_sent, words_checked, setting_cnt + 1);
    $display("predicted output activity: %0d servo writes, %0d digital line writes",
             servo_seen, digital_seen);
    if (mismatch_cnt == 0 && level_expect.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
